// ===== hdl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/wl_pkg.sv =====
// package with shared types and constants for the window level block
`default_nettype none
package wl_pkg;
  localparam logic [1:0] FMT_GRAY  = 2'd0;
  localparam logic [1:0] FMT_RGB16 = 2'd1;
  localparam logic [1:0] FMT_RGB8  = 2'd2;
  localparam logic [1:0] FMT_RGBA8 = 2'd3;
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_LOW    = 2'd1;
  localparam logic [1:0] REG_HIGH   = 2'd2;
  // numerator magnitude 255*|v-lo| fits 41 bits, denominator 33 bits
  localparam int NUM_BITS = 41;
  localparam int DEN_BITS = 33;
  localparam int Q_BITS   = 9;
  typedef struct packed {
    logic         force_mid;
    logic         force_zero;
    logic [NUM_BITS-1:0] num;
  } chan_t;
endpackage
`default_nettype wire

// ===== hdl/wl_stream_if.sv =====
// valid ready stream interface
`default_nettype none
interface wl_stream_if #(parameter int WIDTH = 8);
  logic valid;
  logic ready;
  logic [WIDTH-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/window_level_to_rgb8.sv =====
// window level contrast stretch to 8-bit rgb, top level
// Input channel pix_in carries {gray_sample, red_in, green_in, blue_in,
// alpha_in}; output channel pix_out carries {red_out, green_out,
// blue_out, alpha_out}. Configuration goes through cfg_we/cfg_index/
// cfg_data (format, window low, window high); the user must write it
// only while the block is idle, the block itself does not enforce
// this. The pipeline takes one pixel per clock while pix_out does not
// stall. It has 3 front stages (difference, magnitude, scale by 255),
// one quotient prefix stage, one stage per quotient bit of a
// restoring divider, then a clip stage. Each quotient over 255 is clipped.
// All stages advance together when the output register is free or
// being drained; a stall on pix_out holds every stage in place and
// pix_in.ready falls, so nothing is lost or repeated.
// Reset clears the valid bits and loads format 0, window 0..255.
`default_nettype none
module window_level_to_rgb8 #(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  wl_stream_if.sink   pix_in,
  wl_stream_if.source pix_out
);
  localparam int NW = wl_pkg::NUM_BITS;
  localparam int DW = wl_pkg::DEN_BITS;
  localparam int RW = DW + 1;
  localparam int QW = wl_pkg::Q_BITS;
  localparam int NS = 3 + QW + 1;

  logic [1:0] fmt;
  logic signed [31:0] lo, hi;
  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= wl_pkg::FMT_GRAY;
      lo <= '0;
      hi <= 32'sd255;
    end else if (cfg_we) begin
      case (cfg_index)
        wl_pkg::REG_FORMAT: fmt <= cfg_data[1:0];
        wl_pkg::REG_LOW:    lo <= cfg_data;
        wl_pkg::REG_HIGH:   hi <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [NS-1:0] vld;
  logic adv;
  assign adv = !pix_out.valid || pix_out.ready;
  assign pix_in.ready = adv;

  // input fields
  logic [31:0] gs;
  logic [15:0] ri, gi, bi;
  logic [7:0] ai;
  assign {gs, ri, gi, bi, ai} = pix_in.data;

  // stage 1: differences with sign
  logic signed [33:0] d1 [3];
  logic signed [33:0] den1;
  logic [1:0] fmt1;
  logic [23:0] byt1;
  logic [7:0] a1;
  logic signed [SAMPLE_BITS-1:0] gsx;
  assign gsx = gs[SAMPLE_BITS-1:0];
  always_ff @(posedge clk) begin
    if (adv) begin
      fmt1 <= fmt;
      den1 <= 34'(hi) - 34'(lo);
      byt1 <= {ri[7:0], gi[7:0], bi[7:0]};
      a1 <= (fmt == wl_pkg::FMT_RGBA8) ? ai : 8'd0;
      if (fmt == wl_pkg::FMT_GRAY) begin
        for (int c = 0; c < 3; c++) d1[c] <= 34'(gsx) - 34'(lo);
      end else begin
        d1[0] <= $signed({18'd0, ri}) - 34'(lo);
        d1[1] <= $signed({18'd0, gi}) - 34'(lo);
        d1[2] <= $signed({18'd0, bi}) - 34'(lo);
      end
    end
  end

  // stage 2: magnitudes and sign decisions
  logic [33:0] m2 [3];
  logic [3*3-1:0] flag2;
  logic [DW-1:0] den2;
  logic [1:0] fmt2;
  logic [23:0] byt2;
  logic [7:0] a2;
  always_ff @(posedge clk) begin
    if (adv) begin
      fmt2 <= fmt1;
      byt2 <= byt1;
      a2 <= a1;
      den2 <= DW'(den1 < 0 ? -den1 : den1);
      for (int c = 0; c < 3; c++) begin
        m2[c] <= d1[c] < 0 ? 34'(-d1[c]) : 34'(d1[c]);
        flag2[c*3 +: 3] <= {den1 == 0, (d1[c] == 0) || ((d1[c] < 0) != (den1 < 0)), 1'b0};
      end
    end
  end

  // stage 3: scale by 255
  wl_pkg::chan_t ch3 [3];
  logic [DW-1:0] den3;
  logic [1:0] fmt3;
  logic [23:0] byt3;
  logic [7:0] a3;
  always_ff @(posedge clk) begin
    if (adv) begin
      fmt3 <= fmt2;
      byt3 <= byt2;
      a3 <= a2;
      den3 <= den2;
      for (int c = 0; c < 3; c++) begin
        ch3[c].force_mid <= flag2[c*3+2];
        ch3[c].force_zero <= flag2[c*3+1];
        ch3[c].num <= NW'({m2[c], 8'd0} - {8'd0, m2[c]});
      end
    end
  end

  // quotient overflow test and divider prefix: q>=512 iff num>>9 >= den
  logic [3*NW-1:0] numv [QW+1];
  logic [3*RW-1:0] remv [QW+1];
  logic [3*QW-1:0] qv [QW+1];
  logic [DW-1:0] denv [QW+1];
  logic [2:0] sat [QW+1];
  logic [2:0] mid [QW+1];
  logic [2:0] zer [QW+1];
  logic [1:0] fmtv [QW+1];
  logic [23:0] bytv [QW+1];
  logic [7:0] av [QW+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      denv[0] <= den3;
      fmtv[0] <= fmt3;
      bytv[0] <= byt3;
      av[0] <= a3;
      qv[0] <= '0;
      for (int c = 0; c < 3; c++) begin
        numv[0][c*NW +: NW] <= ch3[c].num;
        sat[0][c] <= (ch3[c].num >> QW) >= NW'(den3);
        remv[0][c*RW +: RW] <= '0;
        mid[0][c] <= ch3[c].force_mid;
        zer[0][c] <= ch3[c].force_zero;
      end
    end
  end

  // divider chain: stage k computes quotient bit QW-1-k; the high prefix
  // of the remainder is taken in full when the quotient is known small
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [3*RW-1:0] rin;
    // first step loads the numerator bits above the quotient range
    always_comb begin
      rin = remv[k];
      if (k == 0) begin
        for (int c = 0; c < 3; c++)
          rin[c*RW +: RW] = RW'(numv[k][c*NW + QW +: NW-QW]);
      end
    end
    wl_div_stage #(.BIT(QW-1-k)) u_div (
      .clk(clk), .en(adv), .den(denv[k]), .rem_in(rin),
      .num_in(numv[k]), .q_in(qv[k]),
      .rem_out(remv[k+1]), .q_out(qv[k+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        numv[k+1] <= numv[k];
        denv[k+1] <= denv[k];
        sat[k+1] <= sat[k];
        mid[k+1] <= mid[k];
        zer[k+1] <= zer[k];
        fmtv[k+1] <= fmtv[k];
        bytv[k+1] <= bytv[k];
        av[k+1] <= av[k];
      end
    end
  end

  // final clip and format select into the output register
  logic [7:0] res [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (mid[QW][c]) res[c] = 8'd128;
      else if (zer[QW][c]) res[c] = 8'd0;
      else if (sat[QW][c] || qv[QW][c*QW + 8]) res[c] = 8'd255;
      else res[c] = qv[QW][c*QW +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fmtv[QW] == wl_pkg::FMT_GRAY) begin
        pix_out.data <= {res[0], res[0], res[0], 8'd0};
      end else if (fmtv[QW] == wl_pkg::FMT_RGB16) begin
        pix_out.data <= {res[0], res[1], res[2], 8'd0};
      end else begin
        pix_out.data <= {bytv[QW], av[QW]};
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      pix_out.valid <= 1'b0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], pix_in.valid};
      pix_out.valid <= vld[NS-1];
    end
  end

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_hold, clk, rst, pix_out.valid && !pix_out.ready, pix_out.valid && $stable(pix_out.data))
  `ASSERT_IMPL(a_ready, clk, rst, pix_out.valid && !pix_out.ready, !pix_in.ready)
  `ASSERT_NEXT(a_shift, clk, rst, adv, vld[0] == $past(pix_in.valid))
endmodule
`default_nettype wire

// ===== hdl/wl_div_stage.sv =====
// one restoring divider step per stage for three channels
`default_nettype none
module wl_div_stage #(
  parameter int BIT = 0
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic [wl_pkg::DEN_BITS-1:0] den,
  input  wire logic [3*(wl_pkg::DEN_BITS+1)-1:0] rem_in,
  input  wire logic [3*wl_pkg::NUM_BITS-1:0] num_in,
  input  wire logic [3*wl_pkg::Q_BITS-1:0] q_in,
  output logic [3*(wl_pkg::DEN_BITS+1)-1:0] rem_out,
  output logic [3*wl_pkg::Q_BITS-1:0] q_out
);
  localparam int RW = wl_pkg::DEN_BITS + 1;
  localparam int QW = wl_pkg::Q_BITS;
  localparam int NW = wl_pkg::NUM_BITS;
  logic [3*RW-1:0] rem_next;
  logic [3*QW-1:0] q_next;
  // shift in the numerator bit and trial subtract
  always_comb begin
    logic [RW:0] t;
    rem_next = rem_in;
    q_next = q_in;
    for (int c = 0; c < 3; c++) begin
      t = {rem_in[c*RW +: RW], num_in[c*NW + BIT]};
      if (t >= {2'b00, den}) begin
        t = t - {2'b00, den};
        q_next[c*QW + BIT] = 1'b1;
      end
      rem_next[c*RW +: RW] = t[RW-1:0];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_next;
      q_out <= q_next;
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/window_level_to_rgb8_tb.sv =====
// self-checking testbench for the window level to rgb8 block
`timescale 1ns / 100ps
`default_nettype none
module window_level_to_rgb8_tb;

  localparam int IN_W  = 32 + 16 * 3 + 8;
  localparam int OUT_W = 32;
  localparam int N_RANDOM = 510;
  localparam int LATENCY = 14;

  typedef struct packed {
    logic [31:0] gray;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [7:0]  alpha;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgb8_t;

  // one directed row: format, window, pixel, typed result when known
  typedef struct {
    logic [1:0]  fmt;
    logic [31:0] lo;
    logic [31:0] hi;
    pixel_t      pix;
    bit          typed;
    rgb8_t       res;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  wl_stream_if #(.WIDTH(IN_W))  pix_in_if ();
  wl_stream_if #(.WIDTH(OUT_W)) pix_out_if ();

  window_level_to_rgb8 u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pix_in(pix_in_if.sink), .pix_out(pix_out_if.source)
  );

  // shadow copy of the configuration
  logic [1:0]  fmt_q;
  logic signed [31:0] lo_q;
  logic signed [31:0] hi_q;

  rgb8_t expected_pixels[$];
  int mismatches;
  bit long_holdoff;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("window_level_to_rgb8 regression: fail");
    $finish;
  end

  // exact window/level stretch of one channel
  function automatic logic [7:0] stretch_chan(longint v, longint lo, longint hi);
    longint num;
    longint den;
    longint q;
    if (hi == lo) return 8'd128;
    num = 255 * (v - lo);
    den = hi - lo;
    if (num == 0 || ((num < 0) != (den < 0))) return 8'd0;
    if (num < 0) num = -num;
    if (den < 0) den = -den;
    q = num / den;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic rgb8_t display_pixel(pixel_t p);
    rgb8_t r;
    longint lo;
    longint hi;
    lo = lo_q;
    hi = hi_q;
    r = '0;
    case (fmt_q)
      wl_pkg::FMT_GRAY: begin
        r.red = stretch_chan(longint'($signed(p.gray)), lo, hi);
        r.green = r.red;
        r.blue = r.red;
      end
      wl_pkg::FMT_RGB16: begin
        r.red   = stretch_chan(longint'({1'b0, p.red}), lo, hi);
        r.green = stretch_chan(longint'({1'b0, p.green}), lo, hi);
        r.blue  = stretch_chan(longint'({1'b0, p.blue}), lo, hi);
      end
      wl_pkg::FMT_RGB8: begin
        r.red = p.red[7:0]; r.green = p.green[7:0]; r.blue = p.blue[7:0];
      end
      default: begin
        r.red = p.red[7:0]; r.green = p.green[7:0]; r.blue = p.blue[7:0];
        r.alpha = p.alpha;
      end
    endcase
    return r;
  endfunction

  // one register write; the caller drops the write enable afterwards
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      wl_pkg::REG_FORMAT: fmt_q = val[1:0];
      wl_pkg::REG_LOW:    lo_q = val;
      default:            hi_q = val;
    endcase
  endtask

  // wait for the pipeline to drain, then settle before a register write
  task automatic drain_pipeline();
    pix_in_if.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic set_window(logic [1:0] fmt, logic [31:0] lo, logic [31:0] hi);
    drain_pipeline();
    write_reg(wl_pkg::REG_FORMAT, {30'd0, fmt});
    write_reg(wl_pkg::REG_LOW, lo);
    write_reg(wl_pkg::REG_HIGH, hi);
    cfg_we <= 1'b0;
  endtask

  // offer one pixel after a random gap and wait for its transfer
  task automatic send_pixel(pixel_t p);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap != 0) begin
      pix_in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in_if.valid <= 1'b1;
    pix_in_if.data <= p;
    @(posedge clk);
    while (!pix_in_if.ready) @(posedge clk);
    expected_pixels.push_back(display_pixel(p));
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    p = 88'({$urandom, $urandom, $urandom});
    case ($urandom_range(0, 5))
      0: p.gray = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      1: p.gray = $urandom_range(0, 300) - 20;
      2: p.gray = lo_q + $signed($urandom_range(0, 600)) - 100;
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) begin
      p.red = 16'($urandom_range(0, 300)); p.green = 16'($urandom_range(0, 300));
    end
    return p;
  endfunction

  // sink side: random stall per item, one long hold-off
  initial begin
    int stall;
    pix_out_if.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (long_holdoff) begin
        pix_out_if.ready <= 1'b0;
        repeat (200) @(posedge clk);
        long_holdoff = 1'b0;
      end
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        pix_out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pix_out_if.ready <= 1'b1;
      @(posedge clk);
      while (!pix_out_if.valid) @(posedge clk);
    end
  end

  // compare each transfer with the oldest expected pixel
  always @(posedge clk) begin
    rgb8_t got;
    rgb8_t want;
    if (!rst && pix_out_if.valid && pix_out_if.ready) begin
      got = pix_out_if.data;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %h", got);
      end else begin
        want = expected_pixels.pop_front();
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.alpha !== want.alpha) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected %h got %h", want, got);
        end
      end
    end
  end

  row_t rows[$];

  task automatic add_row(logic [1:0] fmt, logic [31:0] lo, logic [31:0] hi,
                         pixel_t p, bit typed, rgb8_t res);
    row_t r;
    r.fmt = fmt; r.lo = lo; r.hi = hi; r.pix = p; r.typed = typed; r.res = res;
    rows.push_back(r);
  endtask

  initial begin
    int n;
    int burst;
    bit holdoff_sent;
    rgb8_t want;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_in_if.valid = 1'b0;
    pix_in_if.data = '0;
    mismatches = 0;
    long_holdoff = 1'b0;
    holdoff_sent = 1'b0;
    fmt_q = wl_pkg::FMT_GRAY;
    lo_q = 0;
    hi_q = 255;

    // directed rows: reset window, extremes, every format, special windows
    add_row(wl_pkg::FMT_GRAY, 0, 255, {32'd0, 48'd0, 8'd0}, 1, 32'h0000_0000);
    add_row(wl_pkg::FMT_GRAY, 0, 255, {32'd255, 48'hffff_ffff_ffff, 8'hff}, 1,
            32'hffff_ff00);
    add_row(wl_pkg::FMT_GRAY, 0, 255, {32'd100, 48'd0, 8'd0}, 1, 32'h6464_6400);
    add_row(wl_pkg::FMT_GRAY, 0, 255, {32'h8000_0000, 48'd0, 8'd0}, 1, 32'h0);
    add_row(wl_pkg::FMT_GRAY, 0, 255, {32'h7fff_ffff, 48'd0, 8'd0}, 1, 32'hffff_ff00);
    add_row(wl_pkg::FMT_GRAY, 32'h8000_0000, 32'h7fff_ffff, {32'h8000_0000, 56'd0}, 1,
            32'h0);
    add_row(wl_pkg::FMT_GRAY, 32'h8000_0000, 32'h7fff_ffff, {32'h7fff_ffff, 56'd0}, 1,
            32'hffff_ff00);
    add_row(wl_pkg::FMT_GRAY, 32'h8000_0000, 32'h7fff_ffff, {32'd0, 56'd0}, 0, '0);
    add_row(wl_pkg::FMT_GRAY, 32'h7fff_ffff, 32'h8000_0000, {32'd0, 56'd0}, 0, '0);
    add_row(wl_pkg::FMT_GRAY, 32'h7fff_ffff, 32'h8000_0000, {32'h8000_0000, 56'd0}, 1,
            32'hffff_ff00);
    add_row(wl_pkg::FMT_GRAY, 50, 50, {32'd7, 56'd0}, 1, 32'h8080_8000);
    add_row(wl_pkg::FMT_GRAY, 200, 100, {32'd150, 56'd0}, 0, '0);
    add_row(wl_pkg::FMT_GRAY, -10, 10, {32'd3, 56'd0}, 0, '0);
    add_row(wl_pkg::FMT_RGB16, 0, 65535,
            {32'hffff_ffff, 16'hffff, 16'h0, 16'h8000, 8'hff}, 1, 32'hff00_7f00);
    add_row(wl_pkg::FMT_RGB16, 1000, 1000,
            {32'd0, 16'd5, 16'd1000, 16'hffff, 8'h12}, 1, 32'h8080_8000);
    add_row(wl_pkg::FMT_RGB16, 60000, 100,
            {32'd0, 16'd200, 16'hffff, 16'd30000, 8'h0}, 0, '0);
    add_row(wl_pkg::FMT_RGB8, 0, 255,
            {32'h1234_5678, 16'hab12, 16'hcd34, 16'hef56, 8'h99}, 1, 32'h1234_5600);
    add_row(wl_pkg::FMT_RGB8, 0, 255,
            {32'd0, 16'hffff, 16'hffff, 16'hffff, 8'hff}, 1, 32'hffff_ff00);
    add_row(wl_pkg::FMT_RGBA8, 0, 255,
            {32'd0, 16'hff00, 16'h00ff, 16'h8001, 8'hff}, 1, 32'h00ff_01ff);
    add_row(wl_pkg::FMT_RGBA8, 0, 255,
            {32'hffff_ffff, 16'h0001, 16'h0002, 16'h0003, 8'h00}, 1, 32'h0102_0300);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].fmt != fmt_q || rows[i].lo != lo_q || rows[i].hi != hi_q)
        set_window(rows[i].fmt, rows[i].lo, rows[i].hi);
      if (rows[i].typed) begin
        want = display_pixel(rows[i].pix);
        if (want !== rows[i].res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row %0d: typed %h predicted %h", i, rows[i].res, want);
        end
      end
      send_pixel(rows[i].pix);
    end

    // random phases: fresh format and window, then a burst of pixels
    n = 0;
    while (n < N_RANDOM) begin
      case ($urandom_range(0, 4))
        0: set_window(2'($urandom_range(0, 3)), $urandom, $urandom);
        1: set_window(2'($urandom_range(0, 3)), 32'h8000_0000, 32'h7fff_ffff);
        2: set_window(2'($urandom_range(0, 3)), $urandom_range(0, 100),
                      $urandom_range(0, 100));
        default: begin
          int lo_r;
          lo_r = $urandom_range(0, 60000) - 1000;
          set_window(2'($urandom_range(0, 3)), lo_r, lo_r + $urandom_range(1, 70000));
        end
      endcase
      burst = $urandom_range(10, 50);
      // one long receiver hold-off with enough items to fill the block
      if (n >= 200 && !holdoff_sent) begin
        long_holdoff = 1'b1;
        holdoff_sent = 1'b1;
        burst = 40;
      end
      repeat (burst) begin
        send_pixel(random_pixel());
        n++;
      end
    end
    pix_in_if.valid <= 1'b0;

    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0)
      $display("window_level_to_rgb8 regression: pass");
    else
      $display("window_level_to_rgb8 regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/wl_pkg.sv
hdl/wl_stream_if.sv
hdl/wl_div_stage.sv
hdl/window_level_to_rgb8.sv
tb/sv/window_level_to_rgb8_tb.sv
